// File: rtl/core/euler_to_quaternion_assert.svh
// Assertion macros used by the Euler-to-quaternion port-level checker (etq_checker).
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ETQ_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("euler_to_quaternion: assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define ETQ_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("euler_to_quaternion: assertion failed");

`endif

// File: rtl/core/etq_pkg.sv
// Package with the types, constants and constant functions of the Euler-to-quaternion block.
`default_nettype none
package etq_pkg;

  localparam int ANGLE_BITS     = 32;
  localparam int COMPONENT_BITS = 32;
  localparam int CORDIC_STAGES  = 24;

  localparam logic [63:0]        PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic signed [63:0] KINV_Q60 = 64'sd700114967507363234;
  localparam logic signed [63:0] X_START  =
    KINV_Q60 + ((KINV_Q60 / 64'sd3) >>> (2 * CORDIC_STAGES - 1));

  localparam int PH_SHIFT  = 30 + ANGLE_BITS - 11;
  localparam int OUT_SHIFT = 62 - COMPONENT_BITS;

  localparam logic signed [63:0] OUT_LIM = 64'sd1 <<< (COMPONENT_BITS - 2);

  localparam int TRIG_LAT = CORDIC_STAGES + 7;
  localparam int MUL_LAT  = 4;
  localparam int PIPE_LAT = TRIG_LAT + 2 * MUL_LAT + 2;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_about_x;
    logic signed [ANGLE_BITS-1:0] angle_about_y;
    logic signed [ANGLE_BITS-1:0] angle_about_z;
  } euler_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
  } quat_t;

  // Rounded 2^120 / PI_Q60, the radian-to-turn scale.
  function automatic logic [63:0] rad_factor();
    logic [63:0] r;
    logic [63:0] q;
    r = 64'd1;
    q = 64'd0;
    for (int i = 0; i < 120; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= PI_Q60) begin
        r = r - PI_Q60;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= PI_Q60) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  localparam logic [63:0] K_RAD = rad_factor();
  localparam logic [63:0] K_DEG = ((64'd1 << 62) + 64'd360) / 64'd720;

  // Arctangent of 2^-i in Q60, from the series evaluated in Q62.
  function automatic logic signed [63:0] atan_q60(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        t;
    int unsigned        k;
    sum = 64'sd0;
    if (i == 0) begin
      return $signed((PI_Q60 + 64'd2) >> 2);
    end
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      t = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k[0]) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    return (sum + 64'sd2) >>> 2;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/euler_to_quaternion.sv
// Top level of the Euler-angle to quaternion converter (ZXY, fixed point).
// The block takes one beat of three Q10.21 angles per clock while angle_stall is low,
// and returns one beat of four Q1.30 quaternion components, saturated to +-1.0, for
// each accepted input beat. The pipeline is the 24-stage CORDIC plus seven stages of
// phase reduction and quadrant mapping, two pipelined four-stage Q60 multipliers in
// series, and two stages of summing and rounding. A two-entry output buffer absorbs a
// stall; angle_stall rises only once a result is parked in its second entry.
`default_nettype none
module euler_to_quaternion (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_data,
  input  wire logic            angle_valid,
  output logic                 angle_stall,
  input  wire etq_pkg::euler_t angles,
  output logic                 quat_valid,
  input  wire logic            quat_stall,
  output etq_pkg::quat_t       quat
);

  localparam int LAT = etq_pkg::PIPE_LAT;
  localparam int ML  = etq_pkg::MUL_LAT;

  logic                 angle_in_degrees;
  logic                 en;
  logic [LAT-1:0]       vld;
  logic signed [63:0]   cx;
  logic signed [63:0]   sx;
  logic signed [63:0]   cy;
  logic signed [63:0]   sy;
  logic signed [63:0]   cz;
  logic signed [63:0]   sz;
  logic signed [63:0]   dcz [0:ML-1];
  logic signed [63:0]   dsx [0:ML-1];
  logic signed [63:0]   dsy [0:ML-1];
  logic signed [63:0]   dsz [0:ML-1];
  logic signed [63:0]   cyx;
  logic signed [63:0]   syz;
  logic signed [63:0]   cyz;
  logic signed [63:0]   syx;
  logic signed [63:0]   cysz;
  logic signed [63:0]   cxz;
  logic signed [63:0]   sycz;
  logic signed [63:0]   pw1;
  logic signed [63:0]   pw2;
  logic signed [63:0]   px1;
  logic signed [63:0]   px2;
  logic signed [63:0]   py1;
  logic signed [63:0]   py2;
  logic signed [63:0]   pz1;
  logic signed [63:0]   pz2;
  logic signed [63:0]   sw;
  logic signed [63:0]   sxq;
  logic signed [63:0]   syq;
  logic signed [63:0]   szq;
  etq_pkg::quat_t       fin;
  etq_pkg::quat_t       skid;
  logic                 skid_valid;

  function automatic logic signed [etq_pkg::COMPONENT_BITS-1:0] to_out(
    input logic signed [63:0] v
  );
    logic signed [63:0] o;
    o = (v + (64'sd1 <<< (etq_pkg::OUT_SHIFT - 1))) >>> etq_pkg::OUT_SHIFT;
    if (o > etq_pkg::OUT_LIM) begin
      o = etq_pkg::OUT_LIM;
    end
    if (o < -etq_pkg::OUT_LIM) begin
      o = -etq_pkg::OUT_LIM;
    end
    return o[etq_pkg::COMPONENT_BITS-1:0];
  endfunction

  assign en          = !skid_valid;
  assign angle_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_in_degrees <= 1'b0;
    end else if (cfg_write) begin
      angle_in_degrees <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angle_valid};
    end
  end

  etq_trig u_trig_x (.clk, .en, .deg(angle_in_degrees), .angle(angles.angle_about_x),
                     .cs(cx), .sn(sx));
  etq_trig u_trig_y (.clk, .en, .deg(angle_in_degrees), .angle(angles.angle_about_y),
                     .cs(cy), .sn(sy));
  etq_trig u_trig_z (.clk, .en, .deg(angle_in_degrees), .angle(angles.angle_about_z),
                     .cs(cz), .sn(sz));

  always_ff @(posedge clk) begin
    if (en) begin
      dcz[0] <= cz;
      dsx[0] <= sx;
      dsy[0] <= sy;
      dsz[0] <= sz;
      for (int i = 1; i < ML; i++) begin
        dcz[i] <= dcz[i-1];
        dsx[i] <= dsx[i-1];
        dsy[i] <= dsy[i-1];
        dsz[i] <= dsz[i-1];
      end
    end
  end

  etq_mulq60 u_m_cyx  (.clk, .en, .a(cy), .b(cx), .p(cyx));
  etq_mulq60 u_m_syz  (.clk, .en, .a(sy), .b(sz), .p(syz));
  etq_mulq60 u_m_cyz  (.clk, .en, .a(cy), .b(cz), .p(cyz));
  etq_mulq60 u_m_syx  (.clk, .en, .a(sy), .b(cx), .p(syx));
  etq_mulq60 u_m_cysz (.clk, .en, .a(cy), .b(sz), .p(cysz));
  etq_mulq60 u_m_cxz  (.clk, .en, .a(cx), .b(cz), .p(cxz));
  etq_mulq60 u_m_sycz (.clk, .en, .a(sy), .b(cz), .p(sycz));

  etq_mulq60 u_m_w1 (.clk, .en, .a(cyx),  .b(dcz[ML-1]), .p(pw1));
  etq_mulq60 u_m_w2 (.clk, .en, .a(syz),  .b(dsx[ML-1]), .p(pw2));
  etq_mulq60 u_m_x1 (.clk, .en, .a(cyz),  .b(dsx[ML-1]), .p(px1));
  etq_mulq60 u_m_x2 (.clk, .en, .a(syx),  .b(dsz[ML-1]), .p(px2));
  etq_mulq60 u_m_y1 (.clk, .en, .a(cysz), .b(dsx[ML-1]), .p(py1));
  etq_mulq60 u_m_y2 (.clk, .en, .a(cxz),  .b(dsy[ML-1]), .p(py2));
  etq_mulq60 u_m_z1 (.clk, .en, .a(cyx),  .b(dsz[ML-1]), .p(pz1));
  etq_mulq60 u_m_z2 (.clk, .en, .a(sycz), .b(dsx[ML-1]), .p(pz2));

  always_ff @(posedge clk) begin
    if (en) begin
      sw         <= pw1 - pw2;
      sxq        <= px1 + px2;
      syq        <= py1 + py2;
      szq        <= pz1 - pz2;
      fin.quat_w <= to_out(sw);
      fin.quat_x <= to_out(sxq);
      fin.quat_y <= to_out(syq);
      fin.quat_z <= to_out(szq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!quat_stall) begin
        quat       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (vld[LAT-1]) begin
      if (!quat_valid || !quat_stall) begin
        quat       <= fin;
        quat_valid <= 1'b1;
      end else begin
        skid       <= fin;
        skid_valid <= 1'b1;
      end
    end else if (!quat_stall) begin
      quat_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/etq_mulq60.sv
// Pipelined signed Q60 multiplier with round-to-nearest, built from four 32x32 products.
`default_nettype none
module etq_mulq60 (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic signed [63:0]      p
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg1;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg2;
  logic [62:0]  mag;
  logic         neg3;
  logic [127:0] sum;

  assign sum = {p11, 64'd0} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {64'd0, p00}
             + (128'd1 << 59);

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= a[63] ? (~a + 64'd1) : a;
      mb   <= b[63] ? (~b + 64'd1) : b;
      neg1 <= a[63] ^ b[63];
      p00  <= 64'(ma[31:0]) * 64'(mb[31:0]);
      p01  <= 64'(ma[31:0]) * 64'(mb[63:32]);
      p10  <= 64'(ma[63:32]) * 64'(mb[31:0]);
      p11  <= 64'(ma[63:32]) * 64'(mb[63:32]);
      neg2 <= neg1;
      mag  <= sum[122:60];
      neg3 <= neg2;
      p    <= neg3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/etq_trig.sv
// Half-angle phase reduction and pipelined CORDIC giving the cosine and sine of half of one angle.
`default_nettype none
module etq_trig (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic                                  deg,
  input  wire logic signed [etq_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [63:0]                         cs,
  output logic signed [63:0]                         sn
);

  localparam int AB = etq_pkg::ANGLE_BITS;
  localparam int N  = etq_pkg::CORDIC_STAGES;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quad_t;

  logic [AB-1:0]    mag;
  logic             neg1;
  logic [63:0]      k;
  logic [AB+31:0]   pp_lo;
  logic [AB+31:0]   pp_hi;
  logic             neg2;
  logic [AB+63:0]   ph_sum;
  logic [31:0]      ph;
  logic             neg3;
  logic [31:0]      ph_signed;
  logic [29:0]      resid;
  logic [1:0]       quad4;
  logic [63:0]      t_lo;
  logic [63:0]      t_hi;
  logic [1:0]       quad5;
  logic [95:0]      t_sum;
  logic signed [63:0] cx [0:N];
  logic signed [63:0] cy [0:N];
  logic signed [63:0] cz [0:N];
  logic [1:0]       cq [0:N];

  assign k         = deg ? etq_pkg::K_DEG : etq_pkg::K_RAD;
  assign ph_sum    = {pp_hi, 32'd0} + (AB+64)'(pp_lo)
                   + ((AB+64)'(1) << (etq_pkg::PH_SHIFT - 1));
  assign ph_signed = neg3 ? (~ph + 32'd1) : ph;
  assign t_sum     = {t_hi, 32'd0} + {32'd0, t_lo} + (96'd1 << 30);

  always_ff @(posedge clk) begin
    if (en) begin
      mag   <= angle[AB-1] ? (~angle + AB'(1)) : angle;
      neg1  <= angle[AB-1];
      pp_lo <= (AB+32)'(mag) * (AB+32)'(k[31:0]);
      pp_hi <= (AB+32)'(mag) * (AB+32)'(k[63:32]);
      neg2  <= neg1;
      ph    <= ph_sum[etq_pkg::PH_SHIFT+31:etq_pkg::PH_SHIFT];
      neg3  <= neg2;
      resid <= ph_signed[29:0];
      quad4 <= ph_signed[31:30];
      t_lo  <= 64'(resid) * 64'(etq_pkg::PI_Q60[31:0]);
      t_hi  <= 64'(resid) * 64'(etq_pkg::PI_Q60[63:32]);
      quad5 <= quad4;
      cx[0] <= etq_pkg::X_START;
      cy[0] <= 64'sd0;
      cz[0] <= $signed(t_sum[94:31]);
      cq[0] <= quad5;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [63:0] DA = etq_pkg::atan_q60(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 64'sd0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - DA;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + DA;
        end
        cq[i+1] <= cq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_t'(cq[N]))
        QUAD_FIRST: begin
          cs <= cx[N];
          sn <= cy[N];
        end
        QUAD_SECOND: begin
          cs <= -cy[N];
          sn <= cx[N];
        end
        QUAD_THIRD: begin
          cs <= -cx[N];
          sn <= -cy[N];
        end
        default: begin
          cs <= cy[N];
          sn <= -cx[N];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/etq_checker.sv
// Port-level checker for the Euler-to-quaternion block, bound to its top level.
`default_nettype none
`include "euler_to_quaternion_assert.svh"
module etq_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            cfg_write,
  input wire logic            cfg_data,
  input wire logic            angle_valid,
  input wire logic            angle_stall,
  input wire etq_pkg::euler_t angles,
  input wire logic            quat_valid,
  input wire logic            quat_stall,
  input wire etq_pkg::quat_t  quat
);

  localparam logic signed [etq_pkg::COMPONENT_BITS-1:0] LIM =
    etq_pkg::OUT_LIM[etq_pkg::COMPONENT_BITS-1:0];

  logic in_range;

  assign in_range = quat.quat_w <= LIM && quat.quat_w >= -LIM &&
                    quat.quat_x <= LIM && quat.quat_x >= -LIM &&
                    quat.quat_y <= LIM && quat.quat_y >= -LIM &&
                    quat.quat_z <= LIM && quat.quat_z >= -LIM;

  `ETQ_NEXT(a_out_hold, quat_valid && quat_stall, quat_valid && $stable(quat))
  `ETQ_IMPLIES(a_sat_range, quat_valid, in_range)
  `ETQ_IMPLIES(a_stall_needs_out, angle_stall, quat_valid)
  `ETQ_NEXT(a_skid_drains, angle_stall && !quat_stall, !angle_stall)

endmodule

bind euler_to_quaternion etq_checker u_etq_checker (.*);
`default_nettype wire

// File: verif/quat_checker.sv
// Checker that predicts each quaternion beat from the observed angle beats and compares it.
module quat_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_data,
  input  wire logic            angle_valid,
  input  wire logic            angle_stall,
  input  wire etq_pkg::euler_t angles,
  input  wire logic            quat_valid,
  input  wire logic            quat_stall,
  input  wire etq_pkg::quat_t  quat,
  output int                   errors,
  output int                   pending
);

  logic                  degree_mode;
  etq_pkg::quat_t        expected_quats[$];
  logic signed [63:0]    atan_table[0:etq_pkg::CORDIC_STAGES-1];

  function automatic logic signed [63:0] arctan_pow2(int i);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    acc = 64'sd0;
    if (i == 0) begin
      return $signed((etq_pkg::PI_Q60 + 64'd2) >> 2);
    end
    for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = $signed((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
      acc = (k % 2 == 1) ? acc - term : acc + term;
    end
    return (acc + 64'sd2) >>> 2;
  endfunction

  function automatic logic signed [63:0] mul_q60(logic signed [63:0] a, logic signed [63:0] b);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    logic [63:0]  m;
    neg = a[63] ^ b[63];
    ma = a[63] ? 64'(-a) : a;
    mb = b[63] ? 64'(-b) : b;
    p = {64'd0, ma} * {64'd0, mb};
    p = p + (128'd1 << 59);
    m = p[123:60];
    m[63] = 1'b0;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  task automatic sin_cos(input logic [31:0] raw, input logic deg,
                         output logic signed [63:0] c, output logic signed [63:0] s);
    logic               neg;
    logic [31:0]        mag;
    logic [127:0]       prod;
    logic [31:0]        ph;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    neg = raw[31];
    mag = neg ? -raw : raw;
    prod = {96'd0, mag} * {64'd0, (deg ? etq_pkg::K_DEG : etq_pkg::K_RAD)};
    prod = prod + (128'd1 << (etq_pkg::PH_SHIFT - 1));
    ph = prod[etq_pkg::PH_SHIFT+31:etq_pkg::PH_SHIFT];
    if (neg) ph = -ph;
    prod = {98'd0, ph[29:0]} * {64'd0, etq_pkg::PI_Q60};
    prod = prod + (128'd1 << 30);
    z = prod[94:31];
    x = etq_pkg::KINV_Q60
      + ((etq_pkg::KINV_Q60 / 64'sd3) >>> (2 * etq_pkg::CORDIC_STAGES - 1));
    y = 64'sd0;
    for (int i = 0; i < etq_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_table[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_table[i];
      end
    end
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic [31:0] round_component(logic signed [63:0] v);
    logic signed [63:0] o;
    o = (v + (64'sd1 <<< (etq_pkg::OUT_SHIFT - 1))) >>> etq_pkg::OUT_SHIFT;
    if (o > etq_pkg::OUT_LIM) o = etq_pkg::OUT_LIM;
    if (o < -etq_pkg::OUT_LIM) o = -etq_pkg::OUT_LIM;
    return o[31:0];
  endfunction

  function automatic logic signed [63:0] prod3(logic signed [63:0] a, logic signed [63:0] b,
                                                logic signed [63:0] c);
    return mul_q60(mul_q60(a, b), c);
  endfunction

  task automatic predict_quat(input etq_pkg::euler_t e, input logic deg,
                              output etq_pkg::quat_t q);
    logic signed [63:0] cx, sx, cy, sy, cz, sz;
    sin_cos(e.angle_about_x, deg, cx, sx);
    sin_cos(e.angle_about_y, deg, cy, sy);
    sin_cos(e.angle_about_z, deg, cz, sz);
    q.quat_w = round_component(prod3(cy, cx, cz) - prod3(sy, sz, sx));
    q.quat_x = round_component(prod3(cy, cz, sx) + prod3(sy, cx, sz));
    q.quat_y = round_component(prod3(cy, sz, sx) + prod3(cx, cz, sy));
    q.quat_z = round_component(prod3(cy, cx, sz) - prod3(sy, cz, sx));
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < etq_pkg::CORDIC_STAGES; i++) atan_table[i] = arctan_pow2(i);
  end

  always @(posedge clk) begin
    etq_pkg::quat_t q;
    if (rst) begin
      degree_mode <= 1'b0;
    end else begin
      if (cfg_write) degree_mode <= cfg_data;
      if (angle_valid && !angle_stall) begin
        predict_quat(angles, degree_mode, q);
        expected_quats.push_back(q);
      end
      if (quat_valid && !quat_stall) begin
        if (expected_quats.size() == 0) begin
          report("unexpected beat", quat.quat_w, 32'd0);
        end else begin
          q = expected_quats.pop_front();
          if (quat.quat_w !== q.quat_w) report("quat_w", quat.quat_w, q.quat_w);
          if (quat.quat_x !== q.quat_x) report("quat_x", quat.quat_x, q.quat_x);
          if (quat.quat_y !== q.quat_y) report("quat_y", quat.quat_y, q.quat_y);
          if (quat.quat_z !== q.quat_z) report("quat_z", quat.quat_z, q.quat_z);
        end
      end
    end
    pending <= expected_quats.size();
  end
endmodule

// File: verif/testbench.sv
// Top of the Euler-to-quaternion testbench: clock, reset, stimulus and verdict.
module testbench;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  logic            cfg_data = 1'b0;
  logic            angle_valid = 1'b0;
  logic            angle_stall;
  etq_pkg::euler_t angles = '0;
  logic            quat_valid;
  logic            quat_stall = 1'b0;
  etq_pkg::quat_t  quat;
  int              errors;
  int              pending;
  int              stall_left = 0;

  localparam logic [31:0] HALF_PI = 32'd3294199;
  localparam logic [31:0] PI_Q21  = 32'd6588397;
  localparam logic [31:0] DEG_90  = 32'd90 << 21;

  euler_to_quaternion dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .angle_valid(angle_valid), .angle_stall(angle_stall), .angles(angles),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat)
  );

  quat_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .angle_valid(angle_valid), .angle_stall(angle_stall), .angles(angles),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      quat_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      quat_stall <= 1'b0;
      if (r >= 80) stall_left <= (r >= 97) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_angles(input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                             input bit bursty);
    int gap;
    angle_valid <= 1'b1;
    angles <= {ax, ay, az};
    do @(posedge clk); while (angle_stall);
    gap = bursty ? 0 : pick_gap();
    if (gap > 0) begin
      angle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (angle_valid) begin
      angle_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (etq_pkg::PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic set_degree_mode(input logic mode);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_angle(input logic mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom();
    if (mode) return $signed($urandom_range(0, 1440 << 21)) - $signed(720 << 21);
    return $signed($urandom_range(0, 4 * PI_Q21)) - $signed(2 * PI_Q21);
  endfunction

  task automatic directed_part(input logic mode);
    logic [31:0] quarter;
    quarter = mode ? DEG_90 : HALF_PI;
    send_angles(0, 0, 0, 0);
    send_angles(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_angles(32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_angles(32'hFFFFFFFF, 1, 32'h80000000, 0);
    send_angles(quarter, 0, 0, 0);
    send_angles(0, quarter, 0, 0);
    send_angles(0, 0, quarter, 0);
    send_angles(-quarter, quarter, -quarter, 0);
    send_angles(2 * quarter, 3 * quarter, 4 * quarter, 0);
    send_angles(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 0);
    send_angles(32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0, 0);
  endtask

  task automatic random_part(input logic mode, input int count);
    bit bursty;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) bursty = ($urandom_range(0, 2) == 0);
      if (i == count / 2) drain();
      send_angles(random_angle(mode), random_angle(mode), random_angle(mode), bursty);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part(1'b0);
    random_part(1'b0, 120);
    set_degree_mode(1'b1);
    directed_part(1'b1);
    random_part(1'b1, 120);
    set_degree_mode(1'b0);
    random_part(1'b0, 120);
    set_degree_mode(1'b1);
    random_part(1'b1, 120);
    drain();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/etq_pkg.sv
rtl/core/etq_mulq60.sv
rtl/core/etq_trig.sv
rtl/core/euler_to_quaternion.sv
rtl/core/etq_checker.sv
verif/quat_checker.sv
verif/testbench.sv
